>>> src/websocket_frame_receiver_macros.svh
// Assertion macros for the WebSocket frame receiver.
// Used inside modules that have clk and rst_n in scope; no other dependency.
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("websocket_frame_receiver: check failed");

// Next-cycle implication, checked out of reset.
`define WFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("websocket_frame_receiver: check failed");

`endif

>>> src/wfr_pkg.sv
// Shared types, constants and decode functions of the WebSocket frame receiver.
// No dependencies.
package wfr_pkg;

    localparam int SIZE_BITS   = 24;
    localparam int LEN_W       = 64;
    localparam int LIMIT_RESET = 256 * 1024;

    localparam int KIND_W      = 3;
    localparam int OUT_TDATA_W = 16;

    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    // Opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Length codes of the second header byte
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_TEXT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BINARY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PING   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PONG   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ABORT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DROP   = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data;
        logic              has_data;
        logic              last;
    } result_t;

    function automatic logic is_data_op(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY);
    endfunction

    // Kind of a payload beat; continuations take the kind of the open message.
    function automatic logic [KIND_W-1:0] frame_kind(input logic [3:0] op, input logic bin);
        logic [KIND_W-1:0] k;
        unique case (op)
            OP_CONT:   k = bin ? KIND_BINARY : KIND_TEXT;
            OP_TEXT:   k = KIND_TEXT;
            OP_BINARY: k = KIND_BINARY;
            OP_PING:   k = KIND_PING;
            OP_PONG:   k = KIND_PONG;
            default:   k = KIND_CLOSE;
        endcase
        return k;
    endfunction

endpackage

>>> src/websocket_frame_receiver.sv
// WebSocket frame receiver: byte-serial parser for unmasked server frames.
// A result beat is written into the result queue when its byte is accepted and is offered on m_* from the queue head.
// Throughput: one byte per cycle while the result queue has two free slots; a byte raising
// two results (abort then empty frame) is absorbed by the four-entry result queue.
// Reset (rst_n low, asynchronous): parser waits for a first header byte, no message
// open, result queue empty, max_frame_bytes back to 262144.
`include "websocket_frame_receiver_macros.svh"

module websocket_frame_receiver (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [wfr_pkg::SIZE_BITS-1:0]  cfg_wdata,   // max_frame_bytes
    // received byte stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,     // [7:0] rx_byte
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wfr_pkg::OUT_TDATA_W-1:0] m_tdata,    // [7:0] data, [8] has_data
    output logic [wfr_pkg::KIND_W-1:0]     m_tuser,     // [2:0] kind
    output logic                           m_tlast      // last
);
    import wfr_pkg::*;

    // Parser phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [SIZE_BITS-1:0] max_reg;

    logic [2:0]           phase_reg,     phase_next;
    logic [3:0]           hdr_cnt_reg,   hdr_cnt_next;
    logic                 fin_reg,       fin_next;
    logic [3:0]           opcode_reg,    opcode_next;
    logic [6:0]           len_code_reg,  len_code_next;
    logic [LEN_W-1:0]     accum_reg,     accum_next;
    logic [LEN_W-1:0]     left_reg,      left_next;
    logic                 msg_open_reg,  msg_open_next;
    logic                 msg_bin_reg,   msg_bin_next;
    logic [SIZE_BITS-1:0] msg_size_reg,  msg_size_next;

    // result queue
    result_t              fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg,    wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg,    rd_ptr_next;
    logic [CNT_W-1:0]     count_reg,     count_next;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic    in_acc;
    logic    out_acc;
    result_t head;

    // Accept a byte only while two free slots remain: one byte gives at most two results.
    assign s_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_acc   = s_tvalid && s_tready;

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign out_acc  = m_tvalid && m_tready;
    assign m_tdata  = {{(OUT_TDATA_W - 9){1'b0}}, head.has_data, head.data};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    // ------------------------------------------------------------------
    // Parser next state
    // ------------------------------------------------------------------
    logic [7:0]            b;
    logic                  start;
    logic [LEN_W-1:0]      start_len;
    logic                  over;
    logic                  deliver;
    logic                  status_put;
    logic [SIZE_BITS:0]    size_sum;
    logic [LEN_W-1:0]      left_dec;
    logic [3:0]            need;
    logic [KIND_W-1:0]     cur_kind;
    logic                  cur_last;
    result_t               res0, res1;
    logic                  push0, push1;

    assign b        = s_tdata;
    assign left_dec = left_reg - LEN_W'(1);
    assign need     = (len_code_reg == LEN_CODE16) ? EXT16_BYTES : EXT64_BYTES;
    assign cur_kind = frame_kind(opcode_reg, msg_bin_reg);
    assign cur_last = is_data_op(opcode_reg) ? fin_reg : 1'b1;
    assign over     = (start_len[LEN_W-1:SIZE_BITS] != '0)
                   || (start_len[SIZE_BITS-1:0] > max_reg);
    assign size_sum = {1'b0, msg_size_reg} + {1'b0, start_len[SIZE_BITS-1:0]};

    // Frame start: the short length code or the last extended length byte
    always_comb
    begin
        start     = 1'b0;
        start_len = '0;
        if (in_acc && phase_reg == PH_HDR1 && b[6:0] < LEN_CODE16)
        begin
            start     = 1'b1;
            start_len = LEN_W'(b[6:0]);
        end
        else if (in_acc && phase_reg == PH_EXT && (hdr_cnt_reg + 4'd1) >= need)
        begin
            start     = 1'b1;
            start_len = {accum_reg[LEN_W-9:0], b};
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        len_code_next = len_code_reg;
        accum_next    = accum_reg;
        left_next     = left_reg;
        msg_open_next = msg_open_reg;
        msg_bin_next  = msg_bin_reg;
        msg_size_next = msg_size_reg;
        deliver       = 1'b0;
        status_put    = 1'b0;
        push0         = 1'b0;
        push1         = 1'b0;
        res0          = '0;
        res1          = '0;

        if (in_acc)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    len_code_next = b[6:0];
                    hdr_cnt_next  = '0;
                    accum_next    = '0;
                    // long forms: advance to the extended length bytes
                    if (b[6:0] >= LEN_CODE16)
                        phase_next = PH_EXT;
                end
                PH_EXT:
                begin
                    // shift in big-endian extended length
                    accum_next   = {accum_reg[LEN_W-9:0], b};
                    hdr_cnt_next = hdr_cnt_reg + 4'd1;
                end
                PH_PAYLOAD:
                begin
                    left_next = left_dec;
                    push0     = 1'b1;
                    res0      = '{kind: cur_kind, data: b, has_data: 1'b1, last: 1'b0};
                    if (left_dec == '0)
                    begin
                        res0.last  = cur_last;
                        phase_next = PH_HDR0;
                        if (is_data_op(opcode_reg) && fin_reg)
                        begin
                            msg_open_next = 1'b0;
                            msg_bin_next  = 1'b0;
                            msg_size_next = '0;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (left_reg != '0)
                        left_next = left_dec;
                    if (left_reg <= LEN_W'(1))
                        phase_next = PH_HDR0;
                end
                default:
                begin
                    fin_next    = b[7];
                    opcode_next = b[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase
        end

        // Frame start: length known, decide deliver, skip or status
        if (start)
        begin
            if (over)
            begin
                left_next  = start_len;
                phase_next = PH_SKIP;
            end
            else
            begin
                unique case (opcode_reg) inside
                    OP_TEXT, OP_BINARY:
                    begin
                        if (msg_open_reg)
                        begin
                            status_put    = 1'b1;
                            msg_open_next = 1'b0;
                            msg_bin_next  = 1'b0;
                            msg_size_next = '0;
                        end
                        if (!fin_reg)
                        begin
                            msg_open_next = 1'b1;
                            msg_bin_next  = (opcode_reg == OP_BINARY);
                            msg_size_next = start_len[SIZE_BITS-1:0];
                        end
                        deliver = 1'b1;
                    end
                    OP_CONT:
                    begin
                        if (!msg_open_reg)
                        begin
                            status_put = 1'b1;
                        end
                        else if (size_sum > {1'b0, max_reg})
                        begin
                            status_put    = 1'b1;
                            msg_open_next = 1'b0;
                            msg_bin_next  = 1'b0;
                            msg_size_next = '0;
                        end
                        else
                        begin
                            msg_size_next = size_sum[SIZE_BITS-1:0];
                            deliver       = 1'b1;
                        end
                    end
                    OP_CLOSE:
                    begin
                        msg_open_next = 1'b0;
                        msg_bin_next  = 1'b0;
                        msg_size_next = '0;
                        deliver       = 1'b1;
                    end
                    OP_PING, OP_PONG:
                    begin
                        deliver = 1'b1;
                    end
                    default:
                    begin
                        deliver = 1'b0;
                    end
                endcase

                // status beat: drop for an orphan continuation, abort otherwise
                if (status_put)
                begin
                    push0 = 1'b1;
                    res0  = '{kind: (opcode_reg == OP_CONT && !msg_open_reg) ? KIND_DROP
                                                                             : KIND_ABORT,
                              data: 8'd0, has_data: 1'b0, last: 1'b1};
                end

                if (start_len == '0)
                begin
                    // empty frame: one bare beat if delivered, unless it is a non-final data fragment
                    if (deliver && (!is_data_op(opcode_reg) || fin_reg))
                    begin
                        if (status_put)
                        begin
                            push1 = 1'b1;
                            res1  = '{kind: cur_kind, data: 8'd0, has_data: 1'b0, last: 1'b1};
                        end
                        else
                        begin
                            push0 = 1'b1;
                            res0  = '{kind: cur_kind, data: 8'd0, has_data: 1'b0, last: 1'b1};
                        end
                    end
                    if (deliver && is_data_op(opcode_reg) && fin_reg)
                    begin
                        msg_open_next = 1'b0;
                        msg_bin_next  = 1'b0;
                        msg_size_next = '0;
                    end
                    phase_next = PH_HDR0;
                end
                else
                begin
                    left_next  = start_len;
                    phase_next = deliver ? PH_PAYLOAD : PH_SKIP;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Queue pointers
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(out_acc);
        count_next  = count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg      <= SIZE_BITS'(LIMIT_RESET);
            phase_reg    <= PH_HDR0;
            hdr_cnt_reg  <= '0;
            fin_reg      <= 1'b0;
            opcode_reg   <= '0;
            len_code_reg <= '0;
            accum_reg    <= '0;
            left_reg     <= '0;
            msg_open_reg <= 1'b0;
            msg_bin_reg  <= 1'b0;
            msg_size_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                max_reg <= cfg_wdata;
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            len_code_reg <= len_code_next;
            accum_reg    <= accum_next;
            left_reg     <= left_next;
            msg_open_reg <= msg_open_next;
            msg_bin_reg  <= msg_bin_next;
            msg_size_reg <= msg_size_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    // Queue storage: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (push0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (push1)
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WFR_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `WFR_ASSERT_NOW(a_payload_left, phase_reg == PH_PAYLOAD, left_reg != '0)
    `WFR_ASSERT_NEXT(a_hdr0_to_hdr1, in_acc && phase_reg == PH_HDR0, phase_reg == PH_HDR1)
    `WFR_ASSERT_NOW(a_bare_is_last, m_tvalid && !m_tdata[8], m_tlast)

endmodule

>>> verif/websocket_frame_receiver_test.sv
// Self-checking testbench for websocket_frame_receiver: drives a byte stream of
// frames and compares every result beat with a behavioural parser kept in step.
// Depends on wfr_pkg (types, opcodes, result kinds) and the receiver RTL.
`timescale 1ns / 1ps

module websocket_frame_receiver_test;

    import wfr_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 6;
    localparam int          SETTLE_CYCLES = 4;      // margin after the last owed beat is out
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          HOLD_CYCLES   = 120;    // long receiver hold-off
    localparam int          NUM_PHASES    = 6;
    localparam int          DIRECTED_ROWS = 25;
    localparam int          MAX_PRINTED   = 30;
    localparam logic [6:0]  LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0]  LEN_CODE64    = 7'd127;
    localparam result_t     NO_BEAT       = '0;

    // How the payload length is encoded in the header
    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    // Parser position inside the byte stream
    typedef enum logic [2:0] {AT_HDR0, AT_HDR1, AT_EXT, AT_PAYLOAD, AT_SKIP} parse_phase_t;

    // One row of the directed stimulus: a byte and, where obvious, the beats it raises
    typedef struct {
        logic [7:0]  rx;
        bit          typed;
        int unsigned count;
        result_t     first;
        result_t     second;
    } stim_row_t;

    // ------------------------------------------------------------------
    // Block connections; every input is known from time zero
    // ------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [SIZE_BITS-1:0]   cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    websocket_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    result_t     awaited_results[$];    // beats the block still owes, oldest first
    result_t     parsed_beats[$];       // beats raised by the byte just parsed
    int unsigned mismatches  = 0;
    int unsigned bytes_fed   = 0;
    bit          idle_on     = 1'b1;    // random gaps on both sides
    bit          hold_off_req = 1'b0;   // ask the sink for one long hold-off

    // Frame parser copy: advanced once per accepted byte
    parse_phase_t         p_phase;
    logic                 p_fin;
    logic [3:0]           p_opcode;
    logic [6:0]           p_len_code;
    logic [3:0]           p_ext_count;
    logic [63:0]          p_len_acc;
    logic [63:0]          p_remaining;
    logic                 p_msg_open;
    logic                 p_msg_bin;
    logic [SIZE_BITS-1:0] p_msg_size;
    logic [SIZE_BITS-1:0] p_limit;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic result_t beat(input logic [KIND_W-1:0] kind, input logic [7:0] data,
                                     input logic has_data, input logic last);
        result_t r;
        r.kind     = kind;
        r.data     = data;
        r.has_data = has_data;
        r.last     = last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Frame parser
    // ------------------------------------------------------------------
    // Continuation, text and binary make up messages; everything above is a control
    // or reserved opcode.
    function automatic logic carries_data(input logic [3:0] op);
        return op <= OP_BINARY;
    endfunction

    function automatic logic [KIND_W-1:0] beat_kind();
        case (p_opcode)
            OP_CONT:   return p_msg_bin ? KIND_BINARY : KIND_TEXT;
            OP_TEXT:   return KIND_TEXT;
            OP_BINARY: return KIND_BINARY;
            OP_PING:   return KIND_PING;
            OP_PONG:   return KIND_PONG;
            default:   return KIND_CLOSE;
        endcase
    endfunction

    // Control frames always end on their last beat; data frames only with FIN
    function automatic logic beat_last();
        return carries_data(p_opcode) ? p_fin : 1'b1;
    endfunction

    task automatic forget_message();
        p_msg_open = 1'b0;
        p_msg_bin  = 1'b0;
        p_msg_size = '0;
    endtask

    task automatic reset_parser();
        p_phase     = AT_HDR0;
        p_fin       = 1'b0;
        p_opcode    = '0;
        p_len_code  = '0;
        p_ext_count = '0;
        p_len_acc   = '0;
        p_remaining = '0;
        p_limit     = SIZE_BITS'(LIMIT_RESET);
        forget_message();
    endtask

    task automatic close_frame();
        if (carries_data(p_opcode) && p_fin)
            forget_message();
        p_phase = AT_HDR0;
    endtask

    // Header complete: decide between delivering, skipping and status beats
    task automatic open_frame(input logic [63:0] len);
        logic deliver;
        deliver = 1'b0;
        if (len > 64'(p_limit))
        begin
            // oversized: skip silently, keep the message as it is
            p_remaining = len;
            p_phase     = AT_SKIP;
            return;
        end
        case (p_opcode)
            OP_TEXT, OP_BINARY:
            begin
                // a new data frame supersedes an open message
                if (p_msg_open)
                begin
                    parsed_beats.push_back(beat(KIND_ABORT, 8'h00, 1'b0, 1'b1));
                    forget_message();
                end
                if (!p_fin)
                begin
                    p_msg_open = 1'b1;
                    p_msg_bin  = (p_opcode == OP_BINARY);
                    p_msg_size = len[SIZE_BITS-1:0];
                end
                deliver = 1'b1;
            end
            OP_CONT:
            begin
                if (!p_msg_open)
                    parsed_beats.push_back(beat(KIND_DROP, 8'h00, 1'b0, 1'b1));
                else if (64'(p_msg_size) + len > 64'(p_limit))
                begin
                    parsed_beats.push_back(beat(KIND_ABORT, 8'h00, 1'b0, 1'b1));
                    forget_message();
                end
                else
                begin
                    p_msg_size = p_msg_size + len[SIZE_BITS-1:0];
                    deliver    = 1'b1;
                end
            end
            OP_CLOSE:
            begin
                forget_message();
                deliver = 1'b1;
            end
            OP_PING, OP_PONG:
                deliver = 1'b1;
            default: ;
        endcase

        if (len == 64'd0)
        begin
            // empty frame: one data-less beat if delivered, except for a non-final data fragment
            if (deliver && (!carries_data(p_opcode) || p_fin))
                parsed_beats.push_back(beat(beat_kind(), 8'h00, 1'b0, beat_last()));
            if (deliver)
                close_frame();
            else
                p_phase = AT_HDR0;
            return;
        end
        p_remaining = len;
        p_phase     = deliver ? AT_PAYLOAD : AT_SKIP;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [3:0] ext_needed;
        parsed_beats.delete();
        case (p_phase)
            AT_HDR1:
            begin
                p_len_code  = b[6:0];           // mask bit ignored
                p_ext_count = '0;
                p_len_acc   = '0;
                if (p_len_code < LEN_CODE16)
                    open_frame(64'(p_len_code));
                else
                    p_phase = AT_EXT;
            end
            AT_EXT:
            begin
                ext_needed  = (p_len_code == LEN_CODE16) ? EXT16_BYTES : EXT64_BYTES;
                p_len_acc   = {p_len_acc[55:0], b};
                p_ext_count = p_ext_count + 4'd1;
                if (p_ext_count >= ext_needed)
                    open_frame(p_len_acc);
            end
            AT_PAYLOAD:
            begin
                p_remaining = p_remaining - 64'd1;
                if (p_remaining == 64'd0)
                begin
                    parsed_beats.push_back(beat(beat_kind(), b, 1'b1, beat_last()));
                    close_frame();
                end
                else
                    parsed_beats.push_back(beat(beat_kind(), b, 1'b1, 1'b0));
            end
            AT_SKIP:
            begin
                if (p_remaining != 64'd0)
                    p_remaining = p_remaining - 64'd1;
                if (p_remaining == 64'd0)
                    p_phase = AT_HDR0;
            end
            default:
            begin
                p_fin    = b[7];
                p_opcode = b[3:0];
                p_phase  = AT_HDR1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------
    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Offer one byte and hold it until the block takes it
    task automatic offer_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_fed++;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        offer_byte(b);
        parse_rx_byte(b);
        foreach (parsed_beats[i])
            awaited_results.push_back(parsed_beats[i]);
    endtask

    // Drop valid and wait until every owed beat is out, then let the pipe go quiet
    task automatic settle();
        int unsigned guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [SIZE_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        p_limit    = value;
    endtask

    // Send header, length and body bytes; body may be shorter than len for a frame
    // whose skip never ends
    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic mask, input logic [63:0] len,
                              input len_form_t form, input int unsigned body);
        feed_byte({fin, rsv, op});
        case (form)
            LEN_EXT16:
            begin
                feed_byte({mask, LEN_CODE16});
                feed_byte(len[15:8]);
                feed_byte(len[7:0]);
            end
            LEN_EXT64:
            begin
                feed_byte({mask, LEN_CODE64});
                for (int i = 7; i >= 0; i--)
                    feed_byte(len[i*8 +: 8]);
            end
            default:
                feed_byte({mask, len[6:0]});
        endcase
        repeat (body) feed_byte(8'($urandom_range(0, 255)));
    endtask

    // Mostly short payloads; a few long enough to need the 16-bit form
    function automatic logic [63:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 64'd0;
        if (r < 85)
            return 64'($urandom_range(1, 10));
        if (r < 97)
            return 64'($urandom_range(11, 60));
        return 64'($urandom_range(126, 300));
    endfunction

    // Well-formed message traffic with control frames woven in, plus orphans,
    // reserved opcodes, oversized frames and random headers
    task automatic send_random_frame();
        logic        fin;
        logic [3:0]  op;
        logic [63:0] len;
        len_form_t   form;
        int unsigned r;
        fin = 1'($urandom_range(0, 1));
        r   = $urandom_range(0, 99);
        if (p_msg_open)
        begin
            if (r < 55)
            begin
                op  = OP_CONT;
                fin = ($urandom_range(0, 2) == 0);
            end
            else if (r < 75)
                op = ($urandom_range(0, 1) != 0) ? OP_PING : OP_PONG;
            else if (r < 83)
                op = OP_CLOSE;
            else if (r < 93)
                op = ($urandom_range(0, 1) != 0) ? OP_TEXT : OP_BINARY;
            else
                op = 4'($urandom_range(0, 15));
        end
        else
        begin
            if (r < 45)
                op = ($urandom_range(0, 1) != 0) ? OP_TEXT : OP_BINARY;
            else if (r < 58)
                op = ($urandom_range(0, 1) != 0) ? OP_PING : OP_PONG;
            else if (r < 70)
                op = OP_CLOSE;
            else if (r < 78)
                op = OP_CONT;
            else if (r < 88)
                op = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(3, 7))
                                                 : 4'($urandom_range(11, 15));
            else
                op = 4'($urandom_range(0, 15));
        end

        len = pick_len();
        // push just past a small limit now and then
        if (p_limit < 300 && $urandom_range(0, 11) == 0)
            len = 64'(p_limit) + 64'($urandom_range(1, 6));

        if (len > 64'(LEN_SHORT_MAX))
            form = ($urandom_range(0, 1) != 0) ? LEN_EXT16 : LEN_EXT64;
        else
        begin
            r = $urandom_range(0, 9);
            form = (r < 8) ? LEN_SHORT : ((r == 8) ? LEN_EXT16 : LEN_EXT64);
        end
        send_frame(fin, 3'($urandom_range(0, 7)), op, 1'($urandom_range(0, 1)), len, form,
                   int'(len));
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            else if (hold_left != 0)
                hold_left--;
            else if (stall_left != 0)
                stall_left--;
            else
                stall_left = pick_gap();
            m_tready <= (hold_left == 0) && (stall_left == 0) && rst_n;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every beat taken must match the oldest owed beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected beat kind %0d data %02h has %0b last %0b",
                                          m_tuser, m_tdata[7:0], m_tdata[8], m_tlast));
            else
            begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
                    m_tdata[8] !== want.has_data || m_tlast !== want.last)
                    report_mismatch($sformatf(
                        "beat kind %0d data %02h has %0b last %0b, want %0d %02h %0b %0b",
                        m_tuser, m_tdata[7:0], m_tdata[8], m_tlast,
                        want.kind, want.data, want.has_data, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        #(2_000_000);
        $display("[websocket_frame_receiver] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t            directed_rows[DIRECTED_ROWS];
        logic [SIZE_BITS-1:0] phase_limit[NUM_PHASES];
        int unsigned          phase_bytes[NUM_PHASES];
        int unsigned          target;
        bit                   paused;

        // Walk through the special cases at the reset limit
        directed_rows = '{
            // empty ping: one data-less beat closing the frame
            '{8'h89, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00, 1'b1, 1, beat(KIND_PING, 8'h00, 1'b0, 1'b1), NO_BEAT},
            // one-byte binary with the mask bit set in the length byte
            '{8'h82, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h81, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'hFF, 1'b1, 1, beat(KIND_BINARY, 8'hFF, 1'b1, 1'b1), NO_BEAT},
            // empty non-final text fragment only opens the message
            '{8'h01, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00, 1'b1, 0, NO_BEAT, NO_BEAT},
            // final empty text while open: abort, then the empty text beat
            '{8'h81, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00, 1'b1, 2, beat(KIND_ABORT, 8'h00, 1'b0, 1'b1),
                              beat(KIND_TEXT, 8'h00, 1'b0, 1'b1)},
            // orphan continuation is dropped and its byte skipped
            '{8'h80, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h01, 1'b1, 1, beat(KIND_DROP, 8'h00, 1'b0, 1'b1), NO_BEAT},
            '{8'h55, 1'b1, 0, NO_BEAT, NO_BEAT},
            // close with a 16-bit length of one, payload byte zero
            '{8'h88, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h7E, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h01, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00, 1'b1, 1, beat(KIND_CLOSE, 8'h00, 1'b1, 1'b1), NO_BEAT},
            // reserved opcode with all flag bits set: silent
            '{8'hFF, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00, 1'b1, 0, NO_BEAT, NO_BEAT},
            // two-byte binary fragment finished by an empty continuation
            '{8'h02, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h02, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h12, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h34, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h80, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00, 1'b0, 0, NO_BEAT, NO_BEAT}
        };

        // Limits per random phase: reset value, both extremes, small values where
        // oversize and message growth aborts are frequent, then back to reset value
        phase_limit = '{SIZE_BITS'(LIMIT_RESET), {SIZE_BITS{1'b1}}, '0, SIZE_BITS'(40),
                        SIZE_BITS'(9), SIZE_BITS'(LIMIT_RESET)};
        phase_bytes = '{270, 220, 110, 200, 200, 160};
        paused      = 1'b0;

        reset_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: typed beats where obvious, parser beats elsewhere;
        // the parser is advanced on every row either way
        foreach (directed_rows[i])
        begin
            offer_byte(directed_rows[i].rx);
            parse_rx_byte(directed_rows[i].rx);
            if (directed_rows[i].typed)
            begin
                if (directed_rows[i].count > 0)
                    awaited_results.push_back(directed_rows[i].first);
                if (directed_rows[i].count > 1)
                    awaited_results.push_back(directed_rows[i].second);
            end
            else
                foreach (parsed_beats[j])
                    awaited_results.push_back(parsed_beats[j]);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // change the limit only with the block idle
            if (ph != 0)
            begin
                settle();
                write_limit(phase_limit[ph]);
            end
            // one phase runs flat out on both sides
            idle_on = (ph != 1);

            if (ph == 3)
            begin
                // hold the sink off and keep bytes coming so the input stalls
                idle_on      = 1'b0;
                hold_off_req = 1'b1;
                repeat (8)
                    send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 64'd10, LEN_SHORT, 10);
                idle_on = 1'b1;
            end

            target = bytes_fed + phase_bytes[ph];
            while (bytes_fed < target)
            begin
                send_random_frame();
                // pause the source once until every owed beat has come out
                if (ph == 4 && !paused && bytes_fed + phase_bytes[ph] / 2 >= target)
                begin
                    paused = 1'b1;
                    settle();
                end
            end
        end

        // 64-bit length with the top bit set: skipped for good, so it goes last
        send_frame(1'b1, 3'b000, OP_PONG, 1'b0, 64'h8000_0000_0000_0000, LEN_EXT64, 6);

        settle();
        repeat (8) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", awaited_results.size()));

        if (mismatches == 0)
            $display("[websocket_frame_receiver] OK");
        else
            $display("[websocket_frame_receiver] ERROR");
        $finish;
    end

endmodule
